[rtl/pixel_blend_compositor_assert.svh]
// assertion helpers, expect clk and rst_n in scope
`ifndef PIXEL_BLEND_COMPOSITOR_ASSERT_SVH
`define PIXEL_BLEND_COMPOSITOR_ASSERT_SVH

// consequent in the cycle after the antecedent
`define PBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pixel blend: next-cycle check failed");

// consequent in the same cycle as the antecedent
`define PBC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel blend: same-cycle check failed");

`endif

[rtl/pbc_pkg.sv]
`timescale 1ns / 1ps

package pbc_pkg;

    localparam int CH_W        = 16;
    localparam int OPA_W       = 17;
    localparam int FULL_SHIFT  = 15;
    localparam int CHANNEL_FULL = 1 << FULL_SHIFT;
    localparam int OPA_FRAC    = 16;
    localparam int NCH         = 4;
    localparam int NSTAGE      = 4;

    // weight product src_alpha * opacity
    localparam int W_W    = CH_W + OPA_W;
    localparam int KEEP_W = W_W - 1;
    localparam int PROD_W = CH_W + KEEP_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int QSHIFT = FULL_SHIFT + OPA_FRAC;
    localparam int SAT_W  = NUM_W - QSHIFT + 1;
    localparam int SCR_W  = CH_W + 3;

    localparam logic [W_W-1:0]   DEN   = W_W'(CHANNEL_FULL) << OPA_FRAC;
    localparam logic [NUM_W-1:0] ROUND = NUM_W'(1) << (QSHIFT - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = OPA_W;
    localparam logic [OPA_W-1:0] OPACITY_RESET = OPA_W'(1) << OPA_FRAC;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SCREEN = 2'd1,
        MODE_ADD    = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE = 1'b0,
        CFG_OPACITY    = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        mode_t             mode;
        logic [OPA_W-1:0]  opacity;
    } cfg_t;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
        logic [NSTAGE-1:0] valid;
    } pipe_ctrl_t;

    function automatic logic [CH_W-1:0] sat_full(input logic [SAT_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v > SAT_W'(CHANNEL_FULL))
            r = CH_W'(CHANNEL_FULL);
        else
            r = v[CH_W-1:0];
        return r;
    endfunction

endpackage

[rtl/pbc_cfg_regs.sv]
`timescale 1ns / 1ps

module pbc_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output pbc_pkg::cfg_t                     cfg
);

    pbc_pkg::mode_t                   mode_reg;
    pbc_pkg::mode_t                   mode_next;
    logic [pbc_pkg::OPA_W-1:0]        opacity_reg;
    logic [pbc_pkg::OPA_W-1:0]        opacity_next;

    always_comb
    begin
        mode_next    = mode_reg;
        opacity_next = opacity_reg;
        if (cfg_wr_en)
        begin
            case (pbc_pkg::cfg_idx_t'(cfg_index))
                pbc_pkg::CFG_BLEND_MODE: mode_next = pbc_pkg::mode_t'(cfg_wr_data[1:0]);
                pbc_pkg::CFG_OPACITY:    opacity_next = cfg_wr_data[pbc_pkg::OPA_W-1:0];
                default:                 mode_next = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pbc_pkg::MODE_NORMAL;
            opacity_reg <= pbc_pkg::OPACITY_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            opacity_reg <= opacity_next;
        end
    end

    assign cfg.mode    = mode_reg;
    assign cfg.opacity = opacity_reg;

endmodule

[rtl/pbc_pipe_ctrl.sv]
`timescale 1ns / 1ps
`include "pixel_blend_compositor_assert.svh"

module pbc_pipe_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    output pbc_pkg::pipe_ctrl_t  ctrl
);

    localparam int LAST = pbc_pkg::NSTAGE - 1;

    logic [pbc_pkg::NSTAGE-1:0] valid_reg;
    logic [pbc_pkg::NSTAGE-1:0] valid_next;
    logic [pbc_pkg::NSTAGE-1:0] adv;

    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[LAST] = !valid_reg[LAST] || out_ready;
        for (int k = LAST - 1; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < pbc_pkg::NSTAGE; k++)
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready   = adv[0];
    assign ctrl.load  = adv;
    assign ctrl.valid = valid_reg;

    `PBC_ASSERT_NEXT(a_accept_fills_first, in_valid && in_ready, valid_reg[0])
    `PBC_ASSERT_NOW(a_empty_tail_ready, !valid_reg[LAST], in_ready)
    `PBC_ASSERT_NOW(a_drain_ready, out_ready, in_ready)
    `PBC_ASSERT_NEXT(a_stalled_word_kept, valid_reg[1] && !adv[2], valid_reg[1])

endmodule

[rtl/pbc_datapath.sv]
`timescale 1ns / 1ps

module pbc_datapath
(
    input  logic                                         clk,
    input  pbc_pkg::pipe_ctrl_t                          ctrl,
    input  pbc_pkg::cfg_t                                cfg,
    input  logic [pbc_pkg::NCH-1:0][pbc_pkg::CH_W-1:0]   src,
    input  logic [pbc_pkg::NCH-1:0][pbc_pkg::CH_W-1:0]   dst,
    output logic [pbc_pkg::NCH-1:0][pbc_pkg::CH_W-1:0]   res
);

    localparam int CH_W  = pbc_pkg::CH_W;
    localparam int NCH   = pbc_pkg::NCH;
    localparam int W_W   = pbc_pkg::W_W;
    localparam int SAT_W = pbc_pkg::SAT_W;
    localparam int SCR_W = pbc_pkg::SCR_W;

    // stage a: products
    logic [NCH-1:0][W_W-1:0]      so_a_reg, so_a_next;
    logic [NCH-1:0][2*CH_W-1:0]   sd_a_reg, sd_a_next;
    logic [NCH-1:0][CH_W-1:0]     s_a_reg, d_a_reg;

    // stage b: weight split, simple results
    logic [NCH-1:0][W_W-1:0]      so_b_reg;
    logic [NCH-1:0][CH_W-1:0]     d_b_reg;
    logic [pbc_pkg::KEEP_W-1:0]   keep_b_reg, keep_b_next;
    logic [NCH-1:0][CH_W-1:0]     simple_b_reg, simple_b_next;
    logic                         use_simple_b_reg, use_simple_b_next;

    // stage c: destination times keep
    logic [NCH-1:0][pbc_pkg::PROD_W-1:0] dk_c_reg, dk_c_next;
    logic [NCH-1:0][W_W-1:0]      so_c_reg;
    logic [NCH-1:0][CH_W-1:0]     simple_c_reg;
    logic                         use_simple_c_reg;

    // stage d: rounded result
    logic [NCH-1:0][CH_W-1:0]     res_d_reg, res_d_next;

    logic                         w_zero, w_full;
    logic [SCR_W-1:0]             scr_v;
    logic [CH_W-1:0]              scr_ch, add_ch;
    logic [pbc_pkg::NUM_W-1:0]    num;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            // channel 3 holds the weight itself
            so_a_next[i] = W_W'(src[i]) * W_W'(cfg.opacity);
            sd_a_next[i] = src[i] * dst[i];
        end
    end

    always_comb
    begin
        w_zero      = (so_a_reg[NCH-1] == '0);
        w_full      = (so_a_reg[NCH-1] >= pbc_pkg::DEN);
        keep_b_next = pbc_pkg::KEEP_W'(pbc_pkg::DEN - so_a_reg[NCH-1]);
        scr_v       = '0;
        scr_ch      = '0;
        add_ch      = '0;
        for (int i = 0; i < NCH; i++)
        begin
            scr_v = SCR_W'(s_a_reg[i]) + SCR_W'(d_a_reg[i])
                    - SCR_W'(sd_a_reg[i] >> pbc_pkg::FULL_SHIFT);
            scr_ch = scr_v[SCR_W-1] ? '0 : pbc_pkg::sat_full(SAT_W'(scr_v));
            add_ch = pbc_pkg::sat_full(SAT_W'(s_a_reg[i]) + SAT_W'(d_a_reg[i]));
            case (cfg.mode)
                pbc_pkg::MODE_SCREEN: simple_b_next[i] = scr_ch;
                pbc_pkg::MODE_ADD:    simple_b_next[i] = add_ch;
                default:
                begin
                    if (w_full)
                        simple_b_next[i] = pbc_pkg::sat_full(SAT_W'(s_a_reg[i]));
                    else
                        simple_b_next[i] = pbc_pkg::sat_full(SAT_W'(d_a_reg[i]));
                end
            endcase
        end
        case (cfg.mode)
            pbc_pkg::MODE_SCREEN: use_simple_b_next = 1'b1;
            pbc_pkg::MODE_ADD:    use_simple_b_next = 1'b1;
            default:              use_simple_b_next = w_zero || w_full;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
            dk_c_next[i] = pbc_pkg::PROD_W'(d_b_reg[i]) * pbc_pkg::PROD_W'(keep_b_reg);
    end

    always_comb
    begin
        num = '0;
        for (int i = 0; i < NCH; i++)
        begin
            num = pbc_pkg::NUM_W'(dk_c_reg[i])
                  + (pbc_pkg::NUM_W'(so_c_reg[i]) << pbc_pkg::FULL_SHIFT)
                  + pbc_pkg::ROUND;
            if (use_simple_c_reg)
                res_d_next[i] = simple_c_reg[i];
            else
                res_d_next[i] = pbc_pkg::sat_full(
                    SAT_W'(num[pbc_pkg::NUM_W-1:pbc_pkg::QSHIFT]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            so_a_reg <= so_a_next;
            sd_a_reg <= sd_a_next;
            s_a_reg  <= src;
            d_a_reg  <= dst;
        end
        if (ctrl.load[1])
        begin
            so_b_reg         <= so_a_reg;
            d_b_reg          <= d_a_reg;
            keep_b_reg       <= keep_b_next;
            simple_b_reg     <= simple_b_next;
            use_simple_b_reg <= use_simple_b_next;
        end
        if (ctrl.load[2])
        begin
            dk_c_reg         <= dk_c_next;
            so_c_reg         <= so_b_reg;
            simple_c_reg     <= simple_b_reg;
            use_simple_c_reg <= use_simple_b_reg;
        end
        if (ctrl.load[3])
            res_d_reg <= res_d_next;
    end

    assign res = res_d_reg;

endmodule

[rtl/pixel_blend_compositor.sv]
`timescale 1ns / 1ps
// pixel blend compositor
// s_* channel carries one source and one destination rgba pixel per word,
// m_* channel returns the blended rgba pixel. channels are 16 bits with
// full scale 32768. cfg_* is a plain write port: index 0 blend mode
// (normal over, screen, additive), index 1 opacity (16 fraction bits).
// write configuration only while no pixel is in flight.
// four register stages: products, weight split and simple results,
// destination times keep, round and saturate. m_tvalid is the valid bit of
// the last stage, so an accepted word passes all stage registers in order
// before it leaves; one pixel per clock is taken and delivered while the
// receiver does not stall, and every stage holds one pixel.
// reset clears all stage valid bits and loads blend mode normal, opacity
// 1.0. when the receiver stalls, the last stage holds its word and stages
// behind it keep filling; s_tready drops only once every stage is full.
module pixel_blend_compositor
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pbc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [127:0]                       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [63:0]                        m_tdata
);

    localparam int CH_W = pbc_pkg::CH_W;
    localparam int NCH  = pbc_pkg::NCH;

    pbc_pkg::cfg_t                     cfg;
    pbc_pkg::pipe_ctrl_t               ctrl;
    logic [NCH-1:0][CH_W-1:0]          src;
    logic [NCH-1:0][CH_W-1:0]          dst;
    logic [NCH-1:0][CH_W-1:0]          res;

    assign src = s_tdata[NCH*CH_W-1:0];
    assign dst = s_tdata[2*NCH*CH_W-1:NCH*CH_W];

    pbc_cfg_regs u_cfg_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    pbc_pipe_ctrl u_pipe_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .ctrl      (ctrl)
    );

    pbc_datapath u_datapath
    (
        .clk  (clk),
        .ctrl (ctrl),
        .cfg  (cfg),
        .src  (src),
        .dst  (dst),
        .res  (res)
    );

    assign m_tvalid = ctrl.valid[pbc_pkg::NSTAGE-1];
    assign m_tdata  = res;

endmodule

[tb/pixel_blend_compositor_tb.sv]
`timescale 1ns / 1ps

module pixel_blend_compositor_tb;
    import pbc_pkg::*;

    localparam longint unsigned FULL       = CHANNEL_FULL;
    localparam longint unsigned WEIGHT_ONE = FULL << OPA_FRAC;
    localparam logic [OPA_W-1:0] OPA_ONE   = OPACITY_RESET;
    localparam logic [OPA_W-1:0] OPA_MAX   = '1;
    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam int PIPE_LAT                = NSTAGE;
    localparam int HOLD_CYCLES             = 300;

    typedef logic [NCH-1:0][CH_W-1:0] rgba_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [127:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;

    logic [1:0]       model_mode    = MODE_NORMAL;
    logic [OPA_W-1:0] model_opacity = OPACITY_RESET;
    rgba_t            blend_q[$];
    string            ch_names[NCH] = '{"red", "green", "blue", "alpha"};

    int err_cnt     = 0;
    int pix_sent    = 0;
    int pix_checked = 0;
    int cfg_writes  = 0;
    int burst_left  = 0;
    bit sender_gaps = 1'b1;
    int ready_pct   = 100;
    int hold_req    = 0;
    int hold_cnt    = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    pixel_blend_compositor i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    function automatic logic [CH_W-1:0] clamp_full(input longint unsigned v);
        logic [CH_W-1:0] r;
        if (v > FULL)
            r = CH_W'(FULL);
        else
            r = CH_W'(v);
        return r;
    endfunction

    function automatic rgba_t blend_pixel(input rgba_t src, input rgba_t dst);
        rgba_t           res;
        longint unsigned s;
        longint unsigned d;
        longint unsigned opa;
        longint unsigned w;
        longint unsigned keep;
        longint unsigned num;
        longint          sv;
        int              i;
        opa = model_opacity;
        case (model_mode)
            MODE_SCREEN:
            begin
                for (i = 0; i < NCH; i++)
                begin
                    s = src[i];
                    d = dst[i];
                    sv = longint'(s + d) - longint'((s * d) / FULL);
                    res[i] = (sv < 0) ? '0 : clamp_full(longint'(sv));
                end
            end
            MODE_ADD:
            begin
                for (i = 0; i < NCH; i++)
                begin
                    s = src[i];
                    d = dst[i];
                    res[i] = clamp_full(s + d);
                end
            end
            default:
            begin
                s = src[3];
                w = s * opa;
                if (w == 0)
                begin
                    for (i = 0; i < NCH; i++)
                        res[i] = clamp_full(longint'(dst[i]));
                end
                else if (w >= WEIGHT_ONE)
                begin
                    for (i = 0; i < NCH; i++)
                        res[i] = clamp_full(longint'(src[i]));
                end
                else
                begin
                    keep = WEIGHT_ONE - w;
                    for (i = 0; i < NCH - 1; i++)
                    begin
                        s = src[i];
                        d = dst[i];
                        num = d * keep + s * opa * FULL;
                        res[i] = clamp_full((num + WEIGHT_ONE / 2) / WEIGHT_ONE);
                    end
                    d = dst[3];
                    num = d * keep + w * FULL;
                    res[3] = clamp_full((num + WEIGHT_ONE / 2) / WEIGHT_ONE);
                end
            end
        endcase
        return res;
    endfunction

    function automatic rgba_t mk_rgba(input int r, input int g, input int b, input int a);
        return {CH_W'(a), CH_W'(b), CH_W'(g), CH_W'(r)};
    endfunction

    function automatic rgba_t rand_rgba();
        rgba_t p;
        int    i;
        for (i = 0; i < NCH; i++)
        begin
            case ($urandom_range(0, 9))
                0: p[i] = '0;
                1: p[i] = CH_W'(FULL);
                2: p[i] = CH_W'($urandom_range(0, 65535));
                default: p[i] = CH_W'($urandom_range(0, FULL));
            endcase
        end
        return p;
    endfunction

    // scoreboard: predict on accepted input word, compare on accepted output word
    always @(posedge clk)
    begin : blend_check
        rgba_t want;
        rgba_t got;
        int    i;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                blend_q.push_back(blend_pixel(s_tdata[63:0], s_tdata[127:64]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (blend_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected output word, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = blend_q.pop_front();
                    pix_checked++;
                    for (i = 0; i < NCH; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            err_cnt++;
                            $display("%0t: out_%s mismatch, expected %0d, actual %0d",
                                     $time, ch_names[i], want[i], got[i]);
                        end
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin : ready_gen
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic send_pixel(input rgba_t src, input rgba_t dst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pix_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (blend_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BLEND_MODE)
            model_mode = val[1:0];
        else
            model_opacity = val[OPA_W-1:0];
        cfg_writes++;
    endtask

    task automatic set_config(input logic [1:0] mode, input logic [OPA_W-1:0] opa);
        write_reg(CFG_BLEND_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_OPACITY, CFG_DATA_W'(opa));
    endtask

    task automatic test_reset_state();
        send_pixel(mk_rgba(1000, 2000, 3000, 0), mk_rgba(4000, 5000, 6000, 7000));
        send_pixel(mk_rgba(100, 200, 300, FULL), mk_rgba(9, 8, 7, 6));
        send_pixel(mk_rgba(FULL, 0, 12345, 16384), mk_rgba(0, FULL, 23456, 20000));
        send_pixel(mk_rgba(0, 0, 0, 1), mk_rgba(FULL, FULL, FULL, FULL));
        wait_idle();
    endtask

    task automatic test_normal_over();
        // zero opacity keeps destination
        set_config(MODE_NORMAL, '0);
        send_pixel(mk_rgba(FULL, FULL, FULL, FULL), mk_rgba(11, 22, 33, 44));
        set_config(MODE_NORMAL, OPA_W'(32768));
        send_pixel(mk_rgba(0, 0, 0, FULL), mk_rgba(FULL, FULL, FULL, FULL));
        send_pixel(mk_rgba(FULL, FULL, FULL, FULL), mk_rgba(0, 0, 0, 0));
        // opacity above one, inputs above full scale
        set_config(MODE_NORMAL, OPA_MAX);
        send_pixel(mk_rgba(65535, 65535, 65535, 65535), mk_rgba(0, 0, 0, 0));
        send_pixel(mk_rgba(30000, 65535, 100, 16384), mk_rgba(65535, 1, 32000, 65535));
        set_config(MODE_NORMAL, OPA_ONE);
        send_pixel(mk_rgba(5, 5, 5, 0), mk_rgba(65535, 65535, 65535, 65535));
        // spare mode code runs as normal over
        set_config(MODE_SPARE, OPA_W'(40000));
        send_pixel(mk_rgba(20000, 10000, 5000, 24576), mk_rgba(1000, 2000, 3000, 4000));
        send_pixel(mk_rgba(FULL, 0, FULL, FULL), mk_rgba(0, FULL, 0, 0));
        wait_idle();
    endtask

    task automatic test_screen();
        set_config(MODE_SCREEN, OPA_W'(12345));
        send_pixel(mk_rgba(0, 0, 0, 0), mk_rgba(0, 0, 0, 0));
        send_pixel(mk_rgba(FULL, FULL, FULL, FULL), mk_rgba(FULL, FULL, FULL, FULL));
        send_pixel(mk_rgba(65535, 65535, 40000, 16384), mk_rgba(65535, 40000, 65535, 16384));
        wait_idle();
    endtask

    task automatic test_additive();
        set_config(MODE_ADD, OPA_W'(0));
        send_pixel(mk_rgba(0, 0, 0, 0), mk_rgba(0, 0, 0, 0));
        send_pixel(mk_rgba(16384, 16384, 20000, 1), mk_rgba(16384, 16383, 20000, 32767));
        send_pixel(mk_rgba(65535, 65535, 65535, 65535), mk_rgba(65535, 65535, 65535, 65535));
        wait_idle();
    endtask

    task automatic test_random_sweep();
        int               p;
        int               n;
        logic [1:0]       mode;
        logic [OPA_W-1:0] opa;
        rgba_t            src;
        rgba_t            dst;
        for (p = 0; p < 12; p++)
        begin
            case (p)
                0:  begin mode = MODE_NORMAL; opa = OPA_ONE; end
                1:  begin mode = MODE_NORMAL; opa = '0; end
                2:  begin mode = MODE_NORMAL; opa = OPA_MAX; end
                4:  begin mode = MODE_SCREEN; opa = OPA_W'($urandom_range(0, OPA_MAX)); end
                5:  begin mode = MODE_ADD; opa = OPA_W'($urandom_range(0, OPA_MAX)); end
                6:  begin mode = MODE_SPARE; opa = OPA_W'($urandom_range(0, OPA_ONE)); end
                7:  begin mode = MODE_NORMAL; opa = OPA_W'($urandom_range(0, OPA_MAX)); end
                8:  begin mode = MODE_SCREEN; opa = OPA_ONE; end
                9:  begin mode = MODE_ADD; opa = '0; end
                default: begin mode = MODE_NORMAL; opa = OPA_W'($urandom_range(0, OPA_ONE)); end
            endcase
            set_config(mode, opa);
            if (p % 3 == 0)
            begin
                sender_gaps = 1'b0;
                ready_pct   = 100;
            end
            else
            begin
                sender_gaps = 1'b1;
                ready_pct   = $urandom_range(30, 90);
            end
            for (n = 0; n < 85; n++)
            begin
                src = rand_rgba();
                dst = rand_rgba();
                if ($urandom_range(0, 3) == 0)
                    src[3] = CH_W'($urandom_range(0, 64));
                send_pixel(src, dst);
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int n;
        set_config(MODE_NORMAL, OPA_W'($urandom_range(1, OPA_ONE)));
        sender_gaps = 1'b0;
        ready_pct   = 100;
        hold_req    = HOLD_CYCLES;
        for (n = 0; n < 60; n++)
            send_pixel(rand_rgba(), rand_rgba());
        wait_idle();
        sender_gaps = 1'b1;
        ready_pct   = 70;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= CFG_BLEND_MODE;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_normal_over();
        test_screen();
        test_additive();
        test_random_sweep();
        test_backpressure();

        wait_idle();
        repeat (PIPE_LAT * 2) @(posedge clk);
        err_cnt += blend_q.size();

        $display("sent %0d pixels, checked %0d blended words, %0d register writes", pix_sent,
                 pix_checked, cfg_writes);
        $display("normal over, screen, additive and spare mode, opacity 0 to max, long stall");
        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout after %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
